@@ src/ivs_pkg.sv @@
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared types and command codes for the indexed value stack unit.
// ----------------------------------------------------------------------------
package ivs_pkg;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_POPN  = 3'd2,
    CMD_TOP   = 3'd3,
    CMD_PEEK  = 3'd4,
    CMD_POKE  = 3'd5,
    CMD_CLEAR = 3'd6,
    CMD_DEPTH = 3'd7
  } ivs_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } ivs_in_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  data;
    logic [DEPTH_W-1:0] depth;
  } ivs_out_t;

  typedef struct packed {
    logic issue;
    logic finish;
  } ivs_ctl_t;

endpackage

@@ src/ivs_ram.sv @@
// ----------------------------------------------------------------------------
// ivs_ram
// Generic single-port RAM with write enable and registered read data.
// ----------------------------------------------------------------------------
module ivs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/ivs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ivs_ctrl
// Controller: accepts a command when idle, then waits in ST_RESP for the
// memory read before the datapath registers the result.
// ----------------------------------------------------------------------------
module ivs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output ivs_pkg::ivs_ctl_t ctl
);
  import ivs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    ctl.issue  = 1'b0;
    ctl.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.issue = 1'b1;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        ctl.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ src/ivs_datapath.sv @@
// ----------------------------------------------------------------------------
// ivs_datapath
// Fill level, command decode, entry memory access and result register.
// ----------------------------------------------------------------------------
module ivs_datapath #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ivs_pkg::ivs_ctl_t ctl,
  input  ivs_pkg::ivs_in_t  in_item,
  output logic              out_valid,
  output ivs_pkg::ivs_out_t out_item
);
  import ivs_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [LW-1:0]         fill_r;
  logic [LW-1:0]         fill_nxt;
  logic                  ok_r;
  logic                  ok_nxt;
  logic                  rd_r;
  logic                  rd_nxt;
  logic                  we;
  logic [AW-1:0]         addr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  out_valid_r;
  ivs_out_t              out_item_r;
  logic                  not_empty;
  logic                  idx_ok;

  assign not_empty = (fill_r != '0);
  assign idx_ok    = (32'(in_item.index) < 32'(fill_r));
  assign wdata     = DATA_WIDTH'(in_item.value);

  always_comb begin
    fill_nxt = fill_r;
    ok_nxt   = 1'b0;
    rd_nxt   = 1'b0;
    we       = 1'b0;
    addr     = AW'(in_item.index);
    case (ivs_cmd_t'(in_item.command))
      CMD_PUSH: begin
        ok_nxt = (32'(fill_r) < 32'(CAPACITY));
        addr   = AW'(fill_r);
        we     = ok_nxt;
        if (ok_nxt) begin
          fill_nxt = fill_r + LW'(1);
        end
      end
      CMD_POP: begin
        ok_nxt = not_empty;
        if (not_empty) begin
          fill_nxt = fill_r - LW'(1);
        end
      end
      CMD_POPN: begin
        ok_nxt = (32'(in_item.count) <= 32'(fill_r));
        if (ok_nxt) begin
          fill_nxt = fill_r - LW'(in_item.count);
        end
      end
      CMD_TOP: begin
        ok_nxt = not_empty;
        rd_nxt = 1'b1;
        addr   = AW'(fill_r - LW'(1));
      end
      CMD_PEEK: begin
        ok_nxt = idx_ok;
        rd_nxt = 1'b1;
      end
      CMD_POKE: begin
        ok_nxt = idx_ok;
        we     = idx_ok;
      end
      CMD_CLEAR: begin
        ok_nxt   = 1'b1;
        fill_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b1;
      end
    endcase
  end

  ivs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we && ctl.issue),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.issue) begin
        fill_r <= fill_nxt;
      end
      out_valid_r <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      ok_r <= ok_nxt;
      rd_r <= rd_nxt;
    end
    if (ctl.finish) begin
      out_item_r.ok    <= ok_r;
      out_item_r.data  <= (ok_r && rd_r) ? DATA_W'(rdata) : '0;
      out_item_r.depth <= DEPTH_W'(fill_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ src/indexed_value_stack_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_value_stack_unit
// Stack of data words with push, pop, multi-pop, peek, indexed peek and
// poke, clear and depth commands; one result beat per command.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Each command
// occupies the unit for an accept cycle, in which the entry memory is read
// or written, and a response cycle, in which its registered read data is
// folded into the result; busy is high in that cycle only. The result beat is
// shown on out_item with out_valid high for exactly one cycle, the cycle
// after busy falls, and must be captured then; the next command may be
// accepted in that same cycle. Entries are never cleared in storage; reads
// beyond the current depth fail and return zero data.
module indexed_value_stack_unit #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ivs_pkg::ivs_in_t  in_item,
  output logic              out_valid,
  output ivs_pkg::ivs_out_t out_item
);
  import ivs_pkg::*;

  ivs_ctl_t ctl;

  ivs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  ivs_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
